// ===== rtl/core/iirdf1_pkg.sv =====
package iirdf1_pkg;

    localparam int MAX_ORDER  = 5;
    localparam int ORDER_W    = 3;
    localparam int HIST_DEPTH = MAX_ORDER + 1;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int STEP_W     = $clog2(2 * MAX_ORDER + 1);
    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int CFG_W      = 64;
    localparam int CFG_AW     = 3;
    localparam int NUM_PAIRS  = 3;

    localparam int Q_BITS     = 33;
    localparam int DIV_BITS   = 3;
    localparam int DIV_STEPS  = Q_BITS / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_AW-1:0] CFG_ORDER = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_B01   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_B23   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_B45   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_A01   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_A23   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_A45   = 3'd6;

    localparam logic [CFG_W-1:0] A01_RESET = 64'd16777216;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef struct packed {
        logic    vld;
        logic    neg;
        t_coef   coef;
        t_sample data;
    } t_mac_in;

    typedef struct packed {
        t_sample y;
        t_sample x;
    } t_hist_entry;

    typedef struct packed {
        t_sample sample;
        logic    saturated;
        logic    divide_error;
    } t_div_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_FIN
    } t_div_state;

endpackage

// ===== rtl/core/iirdf1_hist.sv =====
module iirdf1_hist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clear,
    input  logic                                 i_rd_en,
    input  logic [iirdf1_pkg::HIST_AW-1:0]       i_rd_addr,
    input  logic                                 i_wr_en,
    input  logic [iirdf1_pkg::HIST_AW-1:0]       i_wr_addr,
    input  iirdf1_pkg::t_hist_entry              i_wr_data,
    output iirdf1_pkg::t_hist_entry              o_rd_data
);
    import iirdf1_pkg::*;

    t_hist_entry             r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]   r_valid;
    t_hist_entry             r_rd_data;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/core/iirdf1_mac.sv =====
module iirdf1_mac (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  iirdf1_pkg::t_mac_in   i_op,
    output logic                  o_busy,
    output iirdf1_pkg::t_acc      o_acc
);
    import iirdf1_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_neg;
    t_acc                     r_acc;
    t_acc                     prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod     <= i_op.coef * i_op.data;
        r_prod_neg <= i_op.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_op.vld;
            if (r_prod_vld) begin
                r_acc <= r_prod_neg ? (r_acc - prod_ext) : (r_acc + prod_ext);
            end
        end
    end

    assign o_busy = r_prod_vld;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/core/iirdf1_div.sv =====
module iirdf1_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  iirdf1_pkg::t_acc      i_acc,
    input  iirdf1_pkg::t_coef     i_a0,
    output logic                  o_done,
    output iirdf1_pkg::t_div_res  o_res
);
    import iirdf1_pkg::*;

    t_div_state              r_state;
    t_div_state              n_state;
    logic [ACC_W-1:0]        r_mag;
    logic                    r_neg;
    logic                    r_zero;
    logic [COEF_W-1:0]       r_d;
    logic                    r_dneg;
    logic                    r_a0z;
    logic                    r_big;
    logic [COEF_W-1:0]       r_rem;
    logic [Q_BITS-1:0]       r_low;
    logic [Q_BITS-1:0]       r_q;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic [COEF_W-1:0]       n_rem;
    logic [Q_BITS-1:0]       n_low;
    logic [Q_BITS-1:0]       n_q;
    logic                    last_step;
    logic                    qneg;

    assign last_step = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_CHECK;
            D_CHECK: n_state = D_RUN;
            D_RUN:   if (last_step) n_state = D_FIN;
            D_FIN:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_comb begin
        o_done = 1'b0;
        unique case (r_state)
            D_FIN:   o_done = 1'b1;
            default: o_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [COEF_W:0]    rem;
        logic [Q_BITS-1:0]  low;
        logic [Q_BITS-1:0]  q;
        rem = {1'b0, r_rem};
        low = r_low;
        q   = r_q;
        for (int j = 0; j < DIV_BITS; j++) begin
            rem = {rem[COEF_W-1:0], low[Q_BITS-1]};
            low = {low[Q_BITS-2:0], 1'b0};
            if (rem >= {1'b0, r_d}) begin
                rem = rem - {1'b0, r_d};
                q   = {q[Q_BITS-2:0], 1'b1};
            end else begin
                q   = {q[Q_BITS-2:0], 1'b0};
            end
        end
        n_rem = rem[COEF_W-1:0];
        n_low = low;
        n_q   = q;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_neg  <= i_acc[ACC_W-1];
                    r_zero <= (i_acc == '0);
                    r_mag  <= i_acc[ACC_W-1] ? ACC_W'(-i_acc) : ACC_W'(i_acc);
                    r_a0z  <= (i_a0 == '0);
                    r_dneg <= i_a0[COEF_W-1];
                    r_d    <= i_a0[COEF_W-1] ? COEF_W'(-i_a0) : COEF_W'(i_a0);
                end
            end
            D_CHECK: begin
                // quotient of 2^Q_BITS or more always clips
                r_big <= (r_mag[ACC_W-1:Q_BITS] >= (ACC_W - Q_BITS)'(r_d));
                r_rem <= r_mag[Q_BITS+COEF_W-1:Q_BITS];
                r_low <= r_mag[Q_BITS-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            D_RUN: begin
                r_rem <= n_rem;
                r_low <= n_low;
                r_q   <= n_q;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign qneg = r_neg ^ r_dneg;

    always_comb begin
        o_res.divide_error = r_a0z;
        o_res.saturated    = 1'b0;
        o_res.sample       = '0;
        if (r_a0z) begin
            if (!r_zero) begin
                o_res.saturated = 1'b1;
                o_res.sample    = r_neg ? SAT_MIN : SAT_MAX;
            end
        end else if (r_big || (!qneg && (r_q > Q_BITS'(33'h0_7FFF_FFFF)))
                     || (qneg && (r_q > Q_BITS'(33'h0_8000_0000)))) begin
            o_res.saturated = 1'b1;
            o_res.sample    = qneg ? SAT_MIN : SAT_MAX;
        end else begin
            o_res.sample = qneg ? -t_sample'(r_q[SAMPLE_W-1:0])
                                : t_sample'(r_q[SAMPLE_W-1:0]);
        end
    end

endmodule

// ===== rtl/core/iir_direct_form_one_filter_core.sv =====
// Direct-form-I IIR filter core, one sample in flight at a time.
// One shared 32x32 MAC, then a radix-8 serial divide by a0 (11 iterations).
// Reset (sync, active low) and any config register write clear both delay lines at once.
module iir_direct_form_one_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [iirdf1_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  logic [iirdf1_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // [31:0] sample_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [31:0] sample_out
    output logic [1:0]                        m_axis_tuser   // [0] saturated, [1] divide_error
);
    import iirdf1_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_W-1:0]      r_step;
    logic [ORDER_W-1:0]     r_order;
    logic [CFG_W-1:0]       r_b_pairs [NUM_PAIRS];
    logic [CFG_W-1:0]       r_a_pairs [NUM_PAIRS];
    t_sample                r_x0;
    logic [HIST_AW-1:0]     r_ptr;
    logic                   r_out_valid;
    t_div_res               r_out;

    logic                   s_fire;
    logic                   last_step;
    logic [ORDER_W-1:0]     k;
    t_mac_in                mac_op;
    logic                   mac_busy;
    t_acc                   mac_acc;
    logic                   hist_rd_en;
    logic [HIST_AW-1:0]     hist_rd_addr;
    logic                   hist_wr_en;
    logic [HIST_AW-1:0]     hist_wr_addr;
    t_hist_entry            hist_wr_data;
    t_hist_entry            hist_rd_data;
    logic                   div_start;
    logic                   div_done;
    t_div_res               div_res;
    logic                   out_free;
    logic                   load_out;
    logic                   cfg_clear;

    function automatic logic [HIST_AW-1:0] hist_back(logic [HIST_AW-1:0] ptr,
                                                     logic [ORDER_W-1:0] back);
        logic [HIST_AW:0] sum;
        sum = {1'b0, ptr} + (HIST_AW + 1)'(HIST_DEPTH) - (HIST_AW + 1)'(back);
        if (sum >= (HIST_AW + 1)'(HIST_DEPTH)) begin
            sum = sum - (HIST_AW + 1)'(HIST_DEPTH);
        end
        return sum[HIST_AW-1:0];
    endfunction

    function automatic t_coef coef_sel(logic [CFG_W-1:0] pair, logic hi);
        return hi ? t_coef'(pair[CFG_W-1:COEF_W]) : t_coef'(pair[COEF_W-1:0]);
    endfunction

    function automatic logic [CFG_W-1:0] pair_at(logic [CFG_W-1:0] p0,
                                                 logic [CFG_W-1:0] p1,
                                                 logic [CFG_W-1:0] p2,
                                                 logic [ORDER_W-1:0] tap);
        logic [CFG_W-1:0] w;
        case (tap[ORDER_W-1:1])
            2'd0:    w = p0;
            2'd1:    w = p1;
            default: w = p2;
        endcase
        return w;
    endfunction

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign k         = ORDER_W'(r_step >> 1);
    assign last_step = (r_step == STEP_W'({r_order, 1'b0}));
    assign out_free  = !r_out_valid || m_axis_tready;
    assign cfg_clear = i_cfg_we && (i_cfg_addr <= CFG_A45);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_fire) n_state = S_MAC;
            S_MAC:   if (last_step) n_state = S_DRAIN;
            S_DRAIN: if (!mac_busy) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [ORDER_W-1:0] tap_b;
        tap_b         = k + 1'b1;
        s_axis_tready = 1'b0;
        mac_op        = '0;
        hist_rd_en    = 1'b0;
        hist_rd_addr  = hist_back(r_ptr, k);
        div_start     = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_MAC: begin
                mac_op.vld = 1'b1;
                // next tap's history is fetched on even steps
                hist_rd_en = !r_step[0] && (k < r_order);
                if (r_step == '0) begin
                    mac_op.coef = coef_sel(r_b_pairs[0], 1'b0);
                    mac_op.data = r_x0;
                end else if (r_step[0]) begin
                    mac_op.coef = coef_sel(pair_at(r_b_pairs[0], r_b_pairs[1],
                                                   r_b_pairs[2], tap_b), tap_b[0]);
                    mac_op.data = hist_rd_data.x;
                end else begin
                    mac_op.neg  = 1'b1;
                    mac_op.coef = coef_sel(pair_at(r_a_pairs[0], r_a_pairs[1],
                                                   r_a_pairs[2], k), k[0]);
                    mac_op.data = hist_rd_data.y;
                end
            end
            S_DRAIN: begin
                div_start = !mac_busy;
            end
            S_DIV: begin
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    assign hist_wr_en     = load_out;
    assign hist_wr_addr   = hist_back(r_ptr, ORDER_W'(HIST_DEPTH - 1));
    assign hist_wr_data.y = div_res.sample;
    assign hist_wr_data.x = r_x0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_order     <= '0;
            r_b_pairs   <= '{default: '0};
            r_a_pairs   <= '{A01_RESET, '0, '0};
        end else begin
            r_state <= n_state;
            if (s_fire) begin
                r_step <= '0;
            end else if (r_state == S_MAC) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_ptr       <= hist_wr_addr;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ORDER: begin
                        r_order <= (i_cfg_wdata[ORDER_W-1:0] > ORDER_W'(MAX_ORDER))
                                   ? ORDER_W'(MAX_ORDER) : i_cfg_wdata[ORDER_W-1:0];
                    end
                    CFG_B01: r_b_pairs[0] <= i_cfg_wdata;
                    CFG_B23: r_b_pairs[1] <= i_cfg_wdata;
                    CFG_B45: r_b_pairs[2] <= i_cfg_wdata;
                    CFG_A01: r_a_pairs[0] <= i_cfg_wdata;
                    CFG_A23: r_a_pairs[1] <= i_cfg_wdata;
                    CFG_A45: r_a_pairs[2] <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_x0 <= t_sample'(s_axis_tdata);
        end
        if (load_out) begin
            r_out <= div_res;
        end
    end

    iirdf1_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (cfg_clear),
        .i_rd_en   (hist_rd_en),
        .i_rd_addr (hist_rd_addr),
        .i_wr_en   (hist_wr_en),
        .i_wr_addr (hist_wr_addr),
        .i_wr_data (hist_wr_data),
        .o_rd_data (hist_rd_data)
    );

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (s_fire),
        .i_op    (mac_op),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    iirdf1_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_acc   (mac_acc),
        .i_a0    (coef_sel(r_a_pairs[0], 1'b0)),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.sample;
    assign m_axis_tuser  = {r_out.divide_error, r_out.saturated};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import iirdf1_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 50;
    localparam logic [CFG_AW-1:0] CFG_NONE = 3'd7;

    typedef enum logic {ROW_CFG, ROW_SMP} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CFG_AW-1:0] addr;
        logic [CFG_W-1:0]  data;
        logic              chk;
        t_div_res          res;
    } t_stim_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    // per-beat typed expectation from the directed table
    logic     tbl_chk = 1'b0;
    t_div_res tbl_res = '0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int err_cnt      = 0;

    // filter model state
    logic [ORDER_W-1:0] pred_order;
    logic [CFG_W-1:0]   pred_b [NUM_PAIRS];
    logic [CFG_W-1:0]   pred_a [NUM_PAIRS];
    t_sample            hist_x [HIST_DEPTH];
    t_sample            hist_y [HIST_DEPTH];
    t_div_res           filt_q [$];
    t_stim_row          dir_rows [$];

    always #2 i_clk = ~i_clk;

    iir_direct_form_one_filter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic t_coef pair_coef(input logic [CFG_W-1:0] w, input int i);
        return (i % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic filt_apply_cfg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        case (addr)
            CFG_ORDER: begin
                pred_order = (data[ORDER_W-1:0] > MAX_ORDER) ? ORDER_W'(MAX_ORDER)
                                                             : data[ORDER_W-1:0];
            end
            CFG_B01, CFG_B23, CFG_B45: pred_b[addr - CFG_B01] = data;
            CFG_A01, CFG_A23, CFG_A45: pred_a[addr - CFG_A01] = data;
            default: ;
        endcase
        if (addr != CFG_NONE) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
            end
        end
    endtask

    task automatic filt_predict(input t_sample x, output t_div_res r);
        logic signed [127:0] acc;
        logic signed [63:0]  cw, dw, a0w;
        logic [127:0]        mag, dv, quo;
        logic                neg, qneg;
        int                  ord;
        ord = pred_order;
        for (int i = ord; i > 0; i--) begin
            hist_x[i] = hist_x[i-1];
            hist_y[i] = hist_y[i-1];
        end
        hist_x[0] = x;
        hist_y[0] = '0;
        acc = '0;
        for (int i = 0; i <= ord; i++) begin
            cw = pair_coef(pred_b[i/2], i);
            dw = hist_x[i];
            acc = acc + cw * dw;
            if (i > 0) begin
                cw = pair_coef(pred_a[i/2], i);
                dw = hist_y[i];
                acc = acc - cw * dw;
            end
        end
        a0w = pair_coef(pred_a[0], 0);
        neg = acc[127];
        r = '0;
        if (a0w == 0) begin
            r.divide_error = 1'b1;
            if (acc != 0) begin
                r.saturated = 1'b1;
                r.sample = neg ? SAT_MIN : SAT_MAX;
            end
        end else begin
            mag  = neg ? -acc : acc;
            dv   = (a0w < 0) ? -a0w : a0w;
            quo  = mag / dv;
            qneg = neg ^ (a0w < 0);
            if ((!qneg && quo > 128'h7FFF_FFFF) || (qneg && quo > 128'h8000_0000)) begin
                r.saturated = 1'b1;
                r.sample = qneg ? SAT_MIN : SAT_MAX;
            end else begin
                r.sample = qneg ? -quo[31:0] : quo[31:0];
            end
        end
        hist_y[0] = r.sample;
    endtask

    // scoreboard: config and sample beats feed the model, output beats are checked
    always @(posedge i_clk) begin : mon
        t_div_res r, want;
        if (!i_rst_n) begin
            pred_order = '0;
            for (int i = 0; i < NUM_PAIRS; i++) begin
                pred_b[i] = '0;
                pred_a[i] = '0;
            end
            pred_a[0] = A01_RESET;
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
            end
            filt_q.delete();
        end else begin
            if (i_cfg_we)
                filt_apply_cfg(i_cfg_addr, i_cfg_wdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (filt_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_axis_tdata, '0);
                end else begin
                    want = filt_q.pop_front();
                    if (m_axis_tdata !== want.sample)
                        report_mismatch("sample_out", m_axis_tdata, want.sample);
                    if (m_axis_tuser[0] !== want.saturated)
                        report_mismatch("saturated", 32'(m_axis_tuser[0]),
                                        32'(want.saturated));
                    if (m_axis_tuser[1] !== want.divide_error)
                        report_mismatch("divide_error", 32'(m_axis_tuser[1]),
                                        32'(want.divide_error));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                filt_predict(s_axis_tdata, r);
                filt_q.push_back(tbl_chk ? tbl_res : r);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (filt_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [31:0] x, input logic chk, input t_div_res res);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        tbl_chk       <= chk;
        tbl_res       <= res;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic row_cfg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] data);
        dir_rows.push_back('{ROW_CFG, addr, data, 1'b0, t_div_res'('0)});
    endtask

    task automatic row_smp(input logic [31:0] x, input logic chk, input t_div_res res);
        dir_rows.push_back('{ROW_SMP, CFG_ORDER, {32'h0, x}, chk, res});
    endtask

    function automatic t_coef rnd_coef(input int style, input int span);
        if (style == 1)
            return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic t_coef pick_a0(input int style);
        case (style)
            1: return $urandom;
            2: return ($urandom_range(3) == 0) ? '0 : rnd_coef(0, 1 << 26);
            default: begin
                case ($urandom_range(3))
                    1: return $urandom_range(1 << 26, 1 << 23);
                    2: return -$urandom_range(1 << 26, 1 << 23);
                    default: return 32'h0100_0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] rnd_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom;
        if (pick < 85)
            return $urandom_range(1 << 21) - (1 << 20);
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default: return 32'h0;
        endcase
    endfunction

    initial begin : drive
        logic [CFG_W-1:0] w;
        int style;

        // reset state: order 0, b0 = 0
        row_smp(32'h1234_5678, 1'b1, '{32'h0, 1'b0, 1'b0});
        // unity gain passes extremes through
        row_cfg(CFG_B01, 64'h0000_0000_0100_0000);
        row_smp(32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b0, 1'b0});
        row_smp(32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b0, 1'b0});
        row_smp(32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0});
        // gain 2.0 clips at both rails
        row_cfg(CFG_B01, 64'h0000_0000_0200_0000);
        row_smp(32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0});
        row_smp(32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b0});
        row_smp(32'h3FFF_FFFF, 1'b1, '{32'h7FFF_FFFE, 1'b0, 1'b0});
        // a0 = 2.0, quotient truncates toward zero
        row_cfg(CFG_B01, 64'h0000_0000_0100_0000);
        row_cfg(CFG_A01, 64'h0000_0000_0200_0000);
        row_smp(32'h0000_0003, 1'b1, '{32'h0000_0001, 1'b0, 1'b0});
        row_smp(32'hFFFF_FFFD, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0});
        // a0 = -1.0, negating min clips high
        row_cfg(CFG_A01, 64'h0000_0000_FF00_0000);
        row_smp(32'h0000_0005, 1'b1, '{32'hFFFF_FFFB, 1'b0, 1'b0});
        row_smp(32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0});
        // a0 = 0: divide error, sign of acc picks the rail
        row_cfg(CFG_A01, 64'h0);
        row_smp(32'h0000_0001, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b1});
        row_smp(32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1});
        row_smp(32'h8000_0000, 1'b1, '{32'h8000_0000, 1'b1, 1'b1});
        // order 7 clamps to max, full taps
        row_cfg(CFG_ORDER, 64'h7);
        row_cfg(CFG_B01, 64'h0080_0000_0100_0000);
        row_cfg(CFG_B23, 64'hFFC0_0000_0040_0000);
        row_cfg(CFG_B45, 64'h7FFF_FFFF_8000_0000);
        row_cfg(CFG_A01, 64'h0040_0000_0100_0000);
        row_cfg(CFG_A23, 64'hFFE0_0000_0020_0000);
        row_cfg(CFG_A45, 64'h0010_0000_FFF0_0000);
        row_smp(32'h0001_0000, 1'b0, '0);
        row_smp(32'h7FFF_FFFF, 1'b0, '0);
        row_smp(32'h8000_0000, 1'b0, '0);
        row_smp(32'h0000_0000, 1'b0, '0);
        row_smp(32'hFFFF_0000, 1'b0, '0);
        row_smp(32'h0001_0000, 1'b0, '0);
        row_smp(32'h0001_0000, 1'b0, '0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 16;
        rcv_idle_pct = 76;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].addr, dir_rows[i].data);
            end else begin
                send_sample(dir_rows[i].data[31:0], dir_rows[i].chk, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 3)
                0: begin snd_idle_pct = 16; rcv_idle_pct = 76; end
                1: begin snd_idle_pct = 76; rcv_idle_pct = 16; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            style = ph % 3;
            wait_idle();
            if (ph == 0)
                w = 64'd5;
            else if (ph == 1)
                w = 64'd0;
            else
                w = {$urandom, $urandom};
            cfg_write(CFG_ORDER, w);
            for (int j = 0; j < NUM_PAIRS; j++)
                cfg_write(CFG_AW'(CFG_B01 + j),
                          {rnd_coef(style, 1 << 23), rnd_coef(style, 1 << 23)});
            cfg_write(CFG_A01, {rnd_coef(style, 1 << 21), pick_a0(style)});
            cfg_write(CFG_A23, {rnd_coef(style, 1 << 21), rnd_coef(style, 1 << 21)});
            cfg_write(CFG_A45, {rnd_coef(style, 1 << 21), rnd_coef(style, 1 << 21)});
            if (ph == 4)
                cfg_write(CFG_NONE, {$urandom, $urandom});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 3 && k == 10)
                    hold_req++;
                if (ph == 7 && k == 25)
                    wait_idle();
                send_sample(rnd_sample(), 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (filt_q.size() != 0);
        repeat (40) @(negedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
